>>> hdl/bmpbgra_pkg.sv
package bmpbgra_pkg;

    // Image limits and header layout
    localparam logic [31:0] MAX_WIDTH  = 32'd4096;
    localparam logic [31:0] MAX_HEIGHT = 32'd4096;
    localparam logic [31:0] HDR_LEN    = 32'd54;
    localparam logic [31:0] OFF_POS    = 32'd10;
    localparam logic [31:0] WID_POS    = 32'd18;
    localparam logic [31:0] HGT_POS    = 32'd22;
    localparam logic [31:0] DEP_POS    = 32'd28;

    localparam logic [7:0]  SIG_B      = 8'h42;
    localparam logic [7:0]  SIG_M      = 8'h4D;
    localparam logic [15:0] DEPTH_24   = 16'd24;
    localparam logic [15:0] DEPTH_32   = 16'd32;
    localparam logic [7:0]  ALPHA      = 8'hFF;

    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXELS,
        PH_WAIT
    } t_phase;

    typedef enum logic [2:0] {
        ST_PIXEL     = 3'd0,
        ST_SIGNATURE = 3'd1,
        ST_DIMENSION = 3'd2,
        ST_DEPTH     = 3'd3,
        ST_TRUNCATED = 3'd4,
        ST_OFFSET    = 3'd5
    } t_status;

    typedef struct packed {
        logic                 valid;
        logic [31:0]          bgra;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic [DIM_W-1:0]     width;
        logic [DIM_W-1:0]     height;
        t_status              status;
        logic                 last;
    } t_result;

endpackage

>>> hdl/bmpbgra_if.sv
interface bmpbgra_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface bmpbgra_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_bgra;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [2:0]  status;
    logic        last_of_image;

    modport source (
        output valid, output pixel_bgra, output pixel_x, output pixel_y,
        output image_width, output image_height, output status, output last_of_image,
        input ready
    );
    modport sink (
        input valid, input pixel_bgra, input pixel_x, input pixel_y,
        input image_width, input image_height, input status, input last_of_image,
        output ready
    );
endinterface

>>> hdl/bmp_stream_to_bgra_pixels.sv
// Converts a BMP file, fed one byte per word on i_byte, into BGRA pixels with
// destination coordinates on o_pix, flipping bottom-up files to top-down order.
// One byte is taken every clock while the output register is empty or being
// drained; each byte passes through a combinational parse step whose result,
// if any, sits in the output register from the next cycle, so a pixel appears
// in the cycle after its last byte. Input ready drops only while a result
// waits unread in the output register. Errors and the final pixel raise
// last_of_image; bytes after them are dropped until end_of_stream, which
// always returns the block to the start of a new file.
module bmp_stream_to_bgra_pixels
    import bmpbgra_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    bmpbgra_in_if.sink     i_byte,
    bmpbgra_out_if.source  o_pix
);

    t_result  res;
    t_result  r_out;
    logic     r_out_valid;
    logic     step;

    // Accept while the output register is empty or being drained
    assign i_byte.ready = !r_out_valid || o_pix.ready;
    assign step         = i_byte.valid && i_byte.ready;

    bmpbgra_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (i_byte.data_byte),
        .i_eos   (i_byte.end_of_stream),
        .o_res   (res)
    );

    // Output register: load on a new result, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= res.valid;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res.valid) begin
            r_out <= res;
        end
    end

    assign o_pix.valid         = r_out_valid;
    assign o_pix.pixel_bgra    = r_out.bgra;
    assign o_pix.pixel_x       = r_out.x;
    assign o_pix.pixel_y       = r_out.y;
    assign o_pix.image_width   = r_out.width;
    assign o_pix.image_height  = r_out.height;
    assign o_pix.status        = r_out.status;
    assign o_pix.last_of_image = r_out.last;

`ifndef SYNTH
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && res.valid |=> o_pix.valid)
        else $error("parser result not loaded into output register");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid && (o_pix.status != ST_PIXEL) |-> o_pix.last_of_image)
        else $error("error result without last_of_image");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid && !o_pix.ready |-> !i_byte.ready)
        else $error("input accepted while output stalled");
`endif

endmodule

>>> hdl/bmpbgra_parse.sv
module bmpbgra_parse
    import bmpbgra_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_eos,
    output t_result    o_res
);

    t_phase       r_phase, n_phase, n_phase_pre;
    logic [31:0]  r_pos, n_pos;
    logic [31:0]  r_offset, n_offset;
    logic [31:0]  r_width, n_width;
    logic [31:0]  r_height, n_height;
    logic [15:0]  r_depth, n_depth;
    logic [1:0]   r_pad, n_pad;
    logic [11:0]  r_col, n_col;
    logic [11:0]  r_row, n_row;
    logic [1:0]   r_chan, n_chan;
    logic [23:0]  r_stage, n_stage;
    logic         r_dims_known, n_dims_known, dims_pre;

    logic         sig_bad, hdr_end, dim_bad, depth_bad, off_bad;
    t_status      hdr_status;
    logic [31:0]  abs_h;
    logic         skip_done;
    logic         depth32, pad_busy, px_done, last_pix, col_wrap;
    logic [1:0]   last_chan;
    logic [11:0]  dst_y;
    logic         truncated;

    // Decode the current byte against the stored header and pixel counters
    always_comb begin
        sig_bad   = ((r_pos == 32'd0) && (i_byte != SIG_B)) ||
                    ((r_pos == 32'd1) && (i_byte != SIG_M));
        hdr_end   = (r_pos == HDR_LEN - 32'd1);
        abs_h     = r_height[31] ? (32'd0 - r_height) : r_height;
        dim_bad   = r_width[31] || (r_width == 32'd0) || (r_width > MAX_WIDTH) ||
                    (abs_h == 32'd0) || (abs_h > MAX_HEIGHT);
        depth_bad = (r_depth != DEPTH_24) && (r_depth != DEPTH_32);
        off_bad   = r_offset[31] || (r_offset < HDR_LEN);
        if (dim_bad) begin
            hdr_status = ST_DIMENSION;
        end else if (depth_bad) begin
            hdr_status = ST_DEPTH;
        end else if (off_bad) begin
            hdr_status = ST_OFFSET;
        end else begin
            hdr_status = ST_PIXEL;
        end
        skip_done = ((r_pos + 32'd1) == r_offset);
        depth32   = (r_depth == DEPTH_32);
        last_chan = depth32 ? 2'd3 : 2'd2;
        pad_busy  = (r_pad != 2'd0);
        px_done   = !pad_busy && (r_chan == last_chan);
        col_wrap  = (({1'b0, r_col} + 13'd1) >= r_width[12:0]);
        last_pix  = (({1'b0, r_col} + 13'd1) == r_width[12:0]) &&
                    (({1'b0, r_row} + 13'd1) == abs_h[12:0]);
        dst_y     = r_height[31] ? r_row : (abs_h[11:0] - 12'd1 - r_row);
    end

    // Next phase, then collapse to header on end of stream
    always_comb begin
        n_phase_pre = r_phase;
        dims_pre    = r_dims_known;
        unique case (r_phase)
            PH_HEADER: begin
                if (sig_bad) begin
                    n_phase_pre = PH_WAIT;
                end else if (hdr_end) begin
                    if (hdr_status != ST_PIXEL) begin
                        n_phase_pre = PH_WAIT;
                    end else begin
                        dims_pre    = 1'b1;
                        n_phase_pre = (r_offset == HDR_LEN) ? PH_PIXELS : PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                if (skip_done) begin
                    n_phase_pre = PH_PIXELS;
                end
            end
            PH_PIXELS: begin
                if (px_done && last_pix) begin
                    n_phase_pre = PH_WAIT;
                end
            end
            PH_WAIT: begin
                n_phase_pre = PH_WAIT;
            end
            default: begin
                n_phase_pre = PH_WAIT;
            end
        endcase
        truncated    = i_eos && (n_phase_pre != PH_WAIT);
        n_phase      = i_eos ? PH_HEADER : n_phase_pre;
        n_dims_known = i_eos ? 1'b0 : dims_pre;
    end

    // Form the result word for this byte
    always_comb begin
        o_res        = '0;
        o_res.status = ST_PIXEL;
        o_res.width  = dims_pre ? r_width[12:0] : '0;
        o_res.height = dims_pre ? abs_h[12:0] : '0;
        unique case (r_phase)
            PH_HEADER: begin
                if (sig_bad) begin
                    o_res.valid  = 1'b1;
                    o_res.status = ST_SIGNATURE;
                    o_res.last   = 1'b1;
                end else if (hdr_end && (hdr_status != ST_PIXEL)) begin
                    o_res.valid  = 1'b1;
                    o_res.status = hdr_status;
                    o_res.last   = 1'b1;
                end
            end
            PH_PIXELS: begin
                if (px_done) begin
                    o_res.valid = 1'b1;
                    o_res.bgra  = {ALPHA, depth32 ? r_stage : {i_byte, r_stage[15:0]}};
                    o_res.x     = r_col;
                    o_res.y     = dst_y;
                    o_res.last  = last_pix;
                end
            end
            PH_SKIP, PH_WAIT: begin
                o_res.valid = 1'b0;
            end
            default: begin
                o_res.valid = 1'b0;
            end
        endcase
        // a short file overrides whatever this byte produced
        if (truncated) begin
            o_res.valid  = 1'b1;
            o_res.bgra   = '0;
            o_res.x      = '0;
            o_res.y      = '0;
            o_res.status = ST_TRUNCATED;
            o_res.last   = 1'b1;
        end
        o_res.valid = o_res.valid && i_step;
    end

    // Advance header fields, skip counter and pixel counters
    always_comb begin
        n_pos    = r_pos;
        n_offset = r_offset;
        n_width  = r_width;
        n_height = r_height;
        n_depth  = r_depth;
        n_pad    = r_pad;
        n_col    = r_col;
        n_row    = r_row;
        n_chan   = r_chan;
        n_stage  = r_stage;
        case (r_phase)
            PH_HEADER: begin
                if (!sig_bad) begin
                    case (r_pos)
                        OFF_POS:          n_offset[7:0]   = i_byte;
                        OFF_POS + 32'd1:  n_offset[15:8]  = i_byte;
                        OFF_POS + 32'd2:  n_offset[23:16] = i_byte;
                        OFF_POS + 32'd3:  n_offset[31:24] = i_byte;
                        WID_POS:          n_width[7:0]    = i_byte;
                        WID_POS + 32'd1:  n_width[15:8]   = i_byte;
                        WID_POS + 32'd2:  n_width[23:16]  = i_byte;
                        WID_POS + 32'd3:  n_width[31:24]  = i_byte;
                        HGT_POS:          n_height[7:0]   = i_byte;
                        HGT_POS + 32'd1:  n_height[15:8]  = i_byte;
                        HGT_POS + 32'd2:  n_height[23:16] = i_byte;
                        HGT_POS + 32'd3:  n_height[31:24] = i_byte;
                        DEP_POS:          n_depth[7:0]    = i_byte;
                        DEP_POS + 32'd1:  n_depth[15:8]   = i_byte;
                        default:          n_pos           = r_pos;
                    endcase
                    n_pos = hdr_end ? HDR_LEN : (r_pos + 32'd1);
                end
            end
            PH_SKIP: begin
                n_pos = r_pos + 32'd1;
            end
            PH_PIXELS: begin
                if (pad_busy) begin
                    // drop row padding
                    n_pad = r_pad - 2'd1;
                end else if (!px_done) begin
                    case (r_chan)
                        2'd0:    n_stage[7:0]   = i_byte;
                        2'd1:    n_stage[15:8]  = i_byte;
                        2'd2:    n_stage[23:16] = i_byte;
                        default: n_stage        = r_stage;
                    endcase
                    n_chan = r_chan + 2'd1;
                end else begin
                    n_chan  = 2'd0;
                    n_stage = '0;
                    if (!last_pix) begin
                        if (col_wrap) begin
                            n_col = '0;
                            n_row = r_row + 12'd1;
                            n_pad = depth32 ? 2'd0 : r_width[1:0];
                        end else begin
                            n_col = r_col + 12'd1;
                        end
                    end
                end
            end
            default: begin
                n_pos = r_pos;
            end
        endcase
        // a new file starts after the final byte
        if (i_eos) begin
            n_pos    = '0;
            n_offset = '0;
            n_width  = '0;
            n_height = '0;
            n_depth  = '0;
            n_pad    = '0;
            n_col    = '0;
            n_row    = '0;
            n_chan   = '0;
            n_stage  = '0;
        end
    end

    // Hold state between accepted words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_pos        <= '0;
            r_offset     <= '0;
            r_width      <= '0;
            r_height     <= '0;
            r_depth      <= '0;
            r_pad        <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_chan       <= '0;
            r_stage      <= '0;
            r_dims_known <= 1'b0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_offset     <= n_offset;
            r_width      <= n_width;
            r_height     <= n_height;
            r_depth      <= n_depth;
            r_pad        <= n_pad;
            r_col        <= n_col;
            r_row        <= n_row;
            r_chan       <= n_chan;
            r_stage      <= n_stage;
            r_dims_known <= n_dims_known;
        end
    end

`ifndef SYNTH
    a_eos_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_eos |=> (r_phase == PH_HEADER) && (r_pos == 32'd0) && !r_dims_known)
        else $error("parser did not restart after end of stream");

    a_pad_24bpp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pad != 2'd0) |-> (r_phase == PH_PIXELS) && (r_depth == DEPTH_24))
        else $error("row padding pending outside 24-bit pixel data");

    a_wait_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (r_phase == PH_WAIT) && !i_eos |-> !o_res.valid)
        else $error("result produced while discarding trailing bytes");
`endif

endmodule
